>>> rtl/gfa_pkg.sv
// Shared types, constants and the coefficient table of the gamma function approximation.
package gfa_pkg;

   localparam int WORK_FRAC         = 30;
   localparam int XW                = 35;
   localparam int SW                = 34;
   localparam int POLY_ORDER        = 10;
   localparam int CIDX_W            = 4;
   localparam int CNT_W             = 6;
   localparam int MAX_ARGUMENT_DEF  = 16;
   localparam int ARG_FRAC_BITS_DEF = 26;

   localparam logic [1:0] STAT_OK  = 2'd0;
   localparam logic [1:0] STAT_NEG = 2'd1;
   localparam logic [1:0] STAT_SAT = 2'd2;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_YDEC,
      DP_MUL_SETUP,
      DP_MUL_PP,
      DP_MUL_ACC,
      DP_T_UPD,
      DP_S_UPD,
      DP_FIN_PT,
      DP_FIN_3,
      DP_DIV_SETUP_1,
      DP_DIV_SETUP_2,
      DP_DIV_STEP,
      DP_DIV_FIN,
      DP_EMIT_NEG,
      DP_EMIT_BIG
   } dp_op_type;

   typedef enum logic [1:0] {
      MS_TY,
      MS_SU,
      MS_XX,
      MS_PT
   } mul_sel_type;

   typedef enum logic [1:0] {
      RG_LE1,
      RG_LE2,
      RG_LE3,
      RG_GT3
   } region_type;

   typedef enum logic [1:0] {
      AC_OK,
      AC_NEG,
      AC_BIG
   } arg_class_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_RED_CHK,
      CS_MSET,
      CS_MPP,
      CS_MACC,
      CS_MPOST,
      CS_FINAL,
      CS_DIV,
      CS_DFIN,
      CS_EMIT
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type           op;
      mul_sel_type         msel;
      logic [CIDX_W-1:0]   cidx;
      logic [1:0]          kidx;
      logic                emit_calc;
   } dp_cmd_type;

   typedef struct packed {
      arg_class_type arg_class;
      region_type    region;
      logic          y_gt3;
   } dp_stat_type;

   // Horner coefficients in Q30, highest power first.
   function automatic logic signed [SW-1:0] coef(input logic [CIDX_W-1:0] idx);
      logic signed [SW-1:0] c;
      case (idx)
         4'd0:    c = 34'sd72704;
         4'd1:    c = -34'sd369619;
         4'd2:    c = 34'sd1653313;
         4'd3:    c = -34'sd2627176;
         4'd4:    c = 34'sd11782916;
         4'd5:    c = -34'sd226460;
         4'd6:    c = 34'sd79712346;
         4'd7:    c = 34'sd87593945;
         4'd8:    c = 34'sd442210103;
         4'd9:    c = 34'sd453961225;
         4'd10:   c = 34'sd1073741824;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/gfa_ctrl.sv
// Sequencer for range reduction, Horner steps, the final scale and the result strobe.
module gfa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   input  gfa_pkg::dp_stat_type stat,
   output gfa_pkg::dp_cmd_type  cmd
);
   import gfa_pkg::*;

   ctrl_state_type    state_ff, state_in;
   mul_sel_type       msel_ff, msel_in;
   logic [CIDX_W-1:0] cidx_ff, cidx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      msel_ff <= msel_in;
      cidx_ff <= cidx_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      state_in      = state_ff;
      msel_in       = msel_ff;
      cidx_in       = cidx_ff;
      cnt_in        = cnt_ff;
      valid_in      = 1'b0;
      cmd.op        = DP_NOP;
      cmd.msel      = msel_ff;
      cmd.cidx      = cidx_ff;
      cmd.kidx      = cnt_ff[1:0];
      cmd.emit_calc = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            if (start) begin
               case (stat.arg_class)
                  AC_NEG: begin
                     cmd.op   = DP_EMIT_NEG;
                     valid_in = 1'b1;
                  end
                  AC_BIG: begin
                     cmd.op   = DP_EMIT_BIG;
                     valid_in = 1'b1;
                  end
                  default: begin
                     cmd.op   = DP_LOAD;
                     state_in = CS_RED_CHK;
                  end
               endcase
            end
         end
         CS_RED_CHK: begin
            if (stat.y_gt3) begin
               cmd.op  = DP_YDEC;
               msel_in = MS_TY;
            end else begin
               msel_in = MS_SU;
               cidx_in = CIDX_W'(1);
            end
            state_in = CS_MSET;
         end
         CS_MSET: begin
            cmd.op   = DP_MUL_SETUP;
            cnt_in   = '0;
            state_in = CS_MPP;
         end
         CS_MPP: begin
            cmd.op = DP_MUL_PP;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = CS_MACC;
            end
         end
         CS_MACC: begin
            cmd.op   = DP_MUL_ACC;
            state_in = CS_MPOST;
         end
         CS_MPOST: begin
            case (msel_ff)
               MS_TY: begin
                  cmd.op   = DP_T_UPD;
                  state_in = CS_RED_CHK;
               end
               MS_SU: begin
                  cmd.op = DP_S_UPD;
                  if (cidx_ff == CIDX_W'(POLY_ORDER)) begin
                     state_in = CS_FINAL;
                  end else begin
                     cidx_in  = cidx_ff + CIDX_W'(1);
                     state_in = CS_MSET;
                  end
               end
               MS_XX: begin
                  cmd.op   = DP_DIV_SETUP_1;
                  cnt_in   = '0;
                  state_in = CS_DIV;
               end
               default: begin
                  cmd.op   = DP_FIN_PT;
                  state_in = CS_EMIT;
               end
            endcase
         end
         CS_FINAL: begin
            case (stat.region)
               RG_LE1: begin
                  msel_in  = MS_XX;
                  state_in = CS_MSET;
               end
               RG_LE2: begin
                  cmd.op   = DP_DIV_SETUP_2;
                  cnt_in   = '0;
                  state_in = CS_DIV;
               end
               RG_LE3: begin
                  cmd.op   = DP_FIN_3;
                  state_in = CS_EMIT;
               end
               default: begin
                  msel_in  = MS_PT;
                  state_in = CS_MSET;
               end
            endcase
         end
         CS_DIV: begin
            cmd.op = DP_DIV_STEP;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == '1) begin
               state_in = CS_DFIN;
            end
         end
         CS_DFIN: begin
            cmd.op   = DP_DIV_FIN;
            state_in = CS_EMIT;
         end
         CS_EMIT: begin
            cmd.emit_calc = 1'b1;
            valid_in      = 1'b1;
            state_in      = CS_IDLE;
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != CS_IDLE);
   assign rsp_valid = valid_ff;

endmodule

>>> rtl/gfa_dp.sv
// Datapath: argument registers, shared 32x32 multiplier, restoring divider and result registers.
module gfa_dp #(
   parameter int MAX_ARGUMENT  = gfa_pkg::MAX_ARGUMENT_DEF,
   parameter int ARG_FRAC_BITS = gfa_pkg::ARG_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic signed [31:0]   req_x_arg,
   input  gfa_pkg::dp_cmd_type  cmd,
   output gfa_pkg::dp_stat_type stat,
   output logic [63:0]          rsp_gamma_value,
   output logic [1:0]           rsp_status
);
   import gfa_pkg::*;

   localparam logic [XW-1:0] ONE_Q   = XW'(64'd1 << WORK_FRAC);
   localparam logic [63:0]   LIMIT   = 64'(MAX_ARGUMENT) << ARG_FRAC_BITS;
   localparam logic [127:0]  HALF30  = 128'd1 << (WORK_FRAC - 1);

   logic [XW-1:0]        x_ff, x_in;
   logic [XW-1:0]        y_ff, y_in;
   logic [63:0]          t_ff, t_in;
   logic signed [SW-1:0] s_ff, s_in;
   region_type           region_ff, region_in;
   logic                 sat_ff, sat_in;
   logic [63:0]          op_a_ff, op_a_in;
   logic [63:0]          op_b_ff, op_b_in;
   logic [63:0]          pp_ff, pp_in;
   logic [1:0]           psh_ff, psh_in;
   logic [127:0]         acc_ff, acc_in;
   logic [63:0]          rem_ff, rem_in;
   logic [63:0]          lo_ff, lo_in;
   logic [63:0]          d_ff, d_in;
   logic [63:0]          val_ff, val_in;
   logic [63:0]          out_val_ff, out_val_in;
   logic [1:0]           out_stat_ff, out_stat_in;

   logic [63:0]          x_wide;
   logic [XW-1:0]        x_new;
   logic [SW-1:0]        s_mag;
   logic [63:0]          p_val;
   logic [XW-1:0]        u_val;
   logic [63:0]          s_rnd;
   logic signed [SW-1:0] s_r;
   logic [127:0]         acc_rnd;
   logic [127:0]         pp_shifted;
   logic [1:0]           sh_words;
   logic [127:0]         num;
   logic [63:0]          dsr;
   logic [64:0]          rem2;
   logic                 ge;

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      t_ff        <= t_in;
      s_ff        <= s_in;
      region_ff   <= region_in;
      sat_ff      <= sat_in;
      op_a_ff     <= op_a_in;
      op_b_ff     <= op_b_in;
      pp_ff       <= pp_in;
      psh_ff      <= psh_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      lo_ff       <= lo_in;
      d_ff        <= d_in;
      val_ff      <= val_in;
      out_val_ff  <= out_val_in;
      out_stat_ff <= out_stat_in;
   end

   always_comb begin
      x_wide = 64'(req_x_arg[30:0]) << (WORK_FRAC - ARG_FRAC_BITS);
      x_new  = x_wide[XW-1:0];
      if (req_x_arg[31] || (req_x_arg == '0)) begin
         stat.arg_class = AC_NEG;
      end else if (64'(req_x_arg[30:0]) > LIMIT) begin
         stat.arg_class = AC_BIG;
      end else begin
         stat.arg_class = AC_OK;
      end
      stat.region = region_ff;
      stat.y_gt3  = (y_ff > 3 * ONE_Q);

      s_mag = s_ff[SW-1] ? SW'(-s_ff) : SW'(s_ff);
      p_val = s_ff[SW-1] ? '0 : 64'(s_ff);
      u_val = y_ff - 2 * ONE_Q;
      s_rnd = acc_ff[63:0] + HALF30[63:0];
      s_r   = s_rnd[WORK_FRAC +: SW];
      acc_rnd = acc_ff + HALF30;

      sh_words   = {1'b0, psh_ff[1]} + {1'b0, psh_ff[0]};
      pp_shifted = 128'(pp_ff) << {sh_words, 5'd0};

      rem2 = {rem_ff, lo_ff[63]};
      ge   = (rem2 >= {1'b0, d_ff});

      num = '0;
      dsr = '0;

      x_in        = x_ff;
      y_in        = y_ff;
      t_in        = t_ff;
      s_in        = s_ff;
      region_in   = region_ff;
      sat_in      = sat_ff;
      op_a_in     = op_a_ff;
      op_b_in     = op_b_ff;
      pp_in       = pp_ff;
      psh_in      = psh_ff;
      acc_in      = acc_ff;
      rem_in      = rem_ff;
      lo_in       = lo_ff;
      d_in        = d_ff;
      val_in      = val_ff;
      out_val_in  = out_val_ff;
      out_stat_in = out_stat_ff;

      case (cmd.op)
         DP_LOAD: begin
            x_in   = x_new;
            t_in   = 64'd1 << 23;
            sat_in = 1'b0;
            s_in   = coef(CIDX_W'(0));
            if (x_new <= ONE_Q) begin
               region_in = RG_LE1;
               y_in      = x_new + 2 * ONE_Q;
            end else if (x_new <= 2 * ONE_Q) begin
               region_in = RG_LE2;
               y_in      = x_new + ONE_Q;
            end else if (x_new <= 3 * ONE_Q) begin
               region_in = RG_LE3;
               y_in      = x_new;
            end else begin
               region_in = RG_GT3;
               y_in      = x_new;
            end
         end
         DP_YDEC: begin
            y_in = y_ff - ONE_Q;
         end
         DP_MUL_SETUP: begin
            acc_in = '0;
            pp_in  = '0;
            psh_in = '0;
            case (cmd.msel)
               MS_TY: begin
                  op_a_in = t_ff;
                  op_b_in = 64'(y_ff);
               end
               MS_SU: begin
                  op_a_in = 64'(s_mag);
                  op_b_in = 64'(u_val);
               end
               MS_XX: begin
                  op_a_in = 64'(x_ff);
                  op_b_in = 64'(x_ff) + 64'(ONE_Q);
               end
               default: begin
                  op_a_in = p_val;
                  op_b_in = t_ff;
               end
            endcase
         end
         DP_MUL_PP: begin
            // Partial products are registered and summed in the next cycle.
            pp_in  = 64'(op_a_ff[32*cmd.kidx[1] +: 32]) * 64'(op_b_ff[32*cmd.kidx[0] +: 32]);
            psh_in = cmd.kidx;
            acc_in = acc_ff + pp_shifted;
         end
         DP_MUL_ACC: begin
            acc_in = acc_ff + pp_shifted;
         end
         DP_T_UPD: begin
            t_in = acc_rnd[WORK_FRAC +: 64];
            if (acc_rnd[127:WORK_FRAC+64] != '0) begin
               sat_in = 1'b1;
            end
         end
         DP_S_UPD: begin
            s_in = (s_ff[SW-1] ? -s_r : s_r) + coef(cmd.cidx);
         end
         DP_FIN_PT: begin
            val_in = acc_rnd[WORK_FRAC +: 64];
            if (acc_rnd[127:WORK_FRAC+64] != '0) begin
               sat_in = 1'b1;
            end
         end
         DP_FIN_3: begin
            val_in = (p_val + 64'd64) >> 7;
         end
         DP_DIV_SETUP_1, DP_DIV_SETUP_2: begin
            if (cmd.op == DP_DIV_SETUP_1) begin
               dsr = acc_ff[63:0];
               num = (128'(p_val) << 53) + 128'(dsr >> 1);
            end else begin
               dsr = 64'(x_ff);
               num = (128'(p_val) << 23) + 128'(dsr >> 1);
            end
            d_in   = dsr;
            rem_in = num[127:64];
            lo_in  = num[63:0];
            if (num[127:64] >= dsr) begin
               sat_in = 1'b1;
            end
         end
         DP_DIV_STEP: begin
            rem_in = ge ? 64'(rem2 - {1'b0, d_ff}) : rem2[63:0];
            lo_in  = {lo_ff[62:0], ge};
         end
         DP_DIV_FIN: begin
            val_in = lo_ff;
         end
         DP_EMIT_NEG: begin
            out_val_in  = '0;
            out_stat_in = STAT_NEG;
         end
         DP_EMIT_BIG: begin
            out_val_in  = '1;
            out_stat_in = STAT_SAT;
         end
         default: begin
         end
      endcase

      if (cmd.emit_calc) begin
         out_val_in  = sat_ff ? '1 : val_ff;
         out_stat_in = sat_ff ? STAT_SAT : STAT_OK;
      end
   end

   assign rsp_gamma_value = out_val_ff;
   assign rsp_status      = out_stat_ff;

endmodule

>>> rtl/gamma_function_approx.sv
// Top level of the gamma function approximation: controller plus datapath.
//
// Pulse start with the argument on req_x_arg (signed, ARG_FRAC_BITS fraction
// bits) while busy is low; that edge accepts the transaction.
// The result appears on rsp_gamma_value (unsigned Q41.23) and rsp_status for
// exactly one cycle, marked by rsp_valid; the receiver cannot stall it.
// A non-positive or over-limit argument answers in the next cycle without busy.
// Otherwise one shared 32x32 multiplier builds each product from four partial
// products, and a restoring divider serves arguments up to two. The work
// grows with the unit steps taken off an argument above three. Busy stays
// high throughout; the next transaction can be accepted in the cycle the
// result is shown.
// Reset returns the sequencer to idle and drops rsp_valid; no result
// in flight is delivered.
module gamma_function_approx #(
   parameter int MAX_ARGUMENT  = gfa_pkg::MAX_ARGUMENT_DEF,
   parameter int ARG_FRAC_BITS = gfa_pkg::ARG_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_x_arg,
   output logic               rsp_valid,
   output logic [63:0]        rsp_gamma_value,
   output logic [1:0]         rsp_status
);
   import gfa_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   gfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   gfa_dp #(
      .MAX_ARGUMENT  (MAX_ARGUMENT),
      .ARG_FRAC_BITS (ARG_FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .req_x_arg       (req_x_arg),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_gamma_value (rsp_gamma_value),
      .rsp_status      (rsp_status)
   );

endmodule
